@@ rtl/affine_cipher_18_letter_macros.svh @@
`ifndef AFFINE_CIPHER_18_LETTER_MACROS_SVH
`define AFFINE_CIPHER_18_LETTER_MACROS_SVH

// same-cycle implication, disabled in reset
`define AC18_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled in reset
`define AC18_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/affc18_pkg.sv @@
`default_nettype none

package affc18_pkg;

    localparam int unsigned ALPHA_LEN  = 18;
    localparam int unsigned IDX_W      = 5;
    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned CFG_DATA_W = 5;
    localparam int unsigned CFG_IDX_W  = 2;

    localparam logic [CHAR_W-1:0] LOWER_FIRST = 8'h61; // 'a'
    localparam logic [CHAR_W-1:0] LOWER_LAST  = 8'h75; // 'u'
    localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_MULT      = 2'd0,
        REG_KEY_SHIFT     = 2'd1,
        REG_DECIPHER_MODE = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
    } lookup_t;

    localparam logic [CHAR_W-1:0] LETTERS [ALPHA_LEN] = '{
        8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49,
        8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h52, 8'h53, 8'h54, 8'h55
    };

    // 18-entry parallel match
    function automatic lookup_t letter_lookup(input logic [CHAR_W-1:0] c);
        lookup_t r;
        r = '0;
        for (int k = 0; k < ALPHA_LEN; k++) begin
            if (LETTERS[k] == c) begin
                r.hit = 1'b1;
                r.idx = IDX_W'(k);
            end
        end
        return r;
    endfunction

    // value in 0..31 reduced modulo 18
    function automatic logic [IDX_W-1:0] red18(input logic [IDX_W-1:0] v);
        logic [IDX_W-1:0] r;
        r = (v >= IDX_W'(ALPHA_LEN)) ? v - IDX_W'(ALPHA_LEN) : v;
        return r;
    endfunction

    // x mod 18 for x < 324: quotient by reciprocal 57/1024, exact over that range
    function automatic logic [IDX_W-1:0] mod18(input logic [8:0] x);
        logic [14:0] prod;
        logic [8:0]  q;
        logic [8:0]  qm;
        logic [8:0]  rem;
        prod = {6'd0, x} * 15'd57;
        q    = {4'd0, prod[14:10]};
        qm   = (q << 4) + (q << 1);
        rem  = x - qm;
        return rem[IDX_W-1:0];
    endfunction

    // inverse modulo 18, zero when none exists
    function automatic logic [IDX_W-1:0] inv18(input logic [IDX_W-1:0] a);
        logic [IDX_W-1:0] r;
        case (a)
            5'd1:    r = 5'd1;
            5'd5:    r = 5'd11;
            5'd7:    r = 5'd13;
            5'd11:   r = 5'd5;
            5'd13:   r = 5'd7;
            5'd17:   r = 5'd17;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/affine_cipher_18_letter.sv @@
// Affine cipher over the 18-letter alphabet A-I, L-P, R-U, one byte per item. Encipher maps
// letter j to letter (a*j+b) mod 18 after folding lowercase 'a'..'u' to uppercase; decipher
// maps uppercase j to ((j-b) * inverse(a)) mod 18. Other bytes pass through, after the encipher
// fold. With a multiplier that has no inverse mod 18, decipher passes every byte and sets
// key_invalid. Keys are reduced mod 18 when written. Two register stages (input, result): an
// accepted item moves on, raising out_valid, when out_stall allows; one item is accepted every
// cycle when out_stall stays low. Write the keys only while no item is in flight.
`default_nettype none

module affine_cipher_18_letter (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_wr_en,
    input  wire logic [affc18_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [affc18_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [affc18_pkg::CHAR_W-1:0]      char_in,
    input  wire logic                               last_in,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [affc18_pkg::CHAR_W-1:0]           char_out,
    output logic                                    in_alphabet,
    output logic                                    key_invalid,
    output logic                                    last_out
);
    import affc18_pkg::*;

    `include "affine_cipher_18_letter_macros.svh"

    logic [IDX_W-1:0]  key_mult_reg;
    logic [IDX_W-1:0]  key_shift_reg;
    logic              decipher_mode_reg;

    logic              s1_valid_reg;
    logic [CHAR_W-1:0] s1_char_reg;
    logic              s1_last_reg;

    logic              out_valid_reg;
    logic [CHAR_W-1:0] char_out_reg;
    logic              in_alphabet_reg;
    logic              key_invalid_reg;
    logic              last_out_reg;

    logic              out_adv;
    logic              in_accept;

    logic [CHAR_W-1:0] char_fold;
    lookup_t           lk;
    logic [IDX_W-1:0]  inv;
    logic [9:0]        enc_prod;
    logic [9:0]        enc_sum;
    logic [IDX_W-1:0]  enc_idx;
    logic [5:0]        dec_diff;
    logic [IDX_W-1:0]  dec_red;
    logic [9:0]        dec_prod;
    logic [IDX_W-1:0]  dec_idx;

    logic [CHAR_W-1:0] char_out_next;
    logic              in_alphabet_next;
    logic              key_invalid_next;

    assign out_adv   = !out_valid_reg || !out_stall;
    assign in_stall  = s1_valid_reg && !out_adv;
    assign in_accept = in_valid && !in_stall;

    // configuration
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            key_mult_reg      <= IDX_W'(1);
            key_shift_reg     <= '0;
            decipher_mode_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_KEY_MULT:      key_mult_reg      <= red18(cfg_data[IDX_W-1:0]);
                REG_KEY_SHIFT:     key_shift_reg     <= red18(cfg_data[IDX_W-1:0]);
                REG_DECIPHER_MODE: decipher_mode_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (out_adv || !s1_valid_reg)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (in_accept)
        begin
            s1_char_reg <= char_in;
            s1_last_reg <= last_in;
        end
    end

    // cipher datapath
    always_comb begin
        char_fold = s1_char_reg;
        if (!decipher_mode_reg && s1_char_reg >= LOWER_FIRST && s1_char_reg <= LOWER_LAST)
        begin
            char_fold = s1_char_reg - CASE_OFFSET;
        end
        lk  = letter_lookup(char_fold);
        inv = inv18(key_mult_reg);

        enc_prod = {5'd0, key_mult_reg} * {5'd0, lk.idx};
        enc_sum  = enc_prod + {5'd0, key_shift_reg};
        enc_idx  = mod18(enc_sum[8:0]);

        dec_diff = {1'b0, lk.idx} + 6'(ALPHA_LEN) - {1'b0, key_shift_reg};
        dec_red  = (dec_diff >= 6'(ALPHA_LEN)) ? IDX_W'(dec_diff - 6'(ALPHA_LEN))
                                               : dec_diff[IDX_W-1:0];
        dec_prod = {5'd0, dec_red} * {5'd0, inv};
        dec_idx  = mod18(dec_prod[8:0]);

        in_alphabet_next = lk.hit;
        key_invalid_next = decipher_mode_reg && (inv == '0);
        char_out_next    = char_fold;
        if (lk.hit && !key_invalid_next)
        begin
            char_out_next = decipher_mode_reg ? LETTERS[dec_idx] : LETTERS[enc_idx];
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (out_adv && s1_valid_reg)
        begin
            char_out_reg    <= char_out_next;
            in_alphabet_reg <= in_alphabet_next;
            key_invalid_reg <= key_invalid_next;
            last_out_reg    <= s1_last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign char_out    = char_out_reg;
    assign in_alphabet = in_alphabet_reg;
    assign key_invalid = key_invalid_reg;
    assign last_out    = last_out_reg;

    `AC18_ASSERT_IMPL(a_stall_full, clk, rst_n, in_stall, s1_valid_reg && out_valid_reg)
    `AC18_ASSERT_NEXT(a_s1_to_out, clk, rst_n, s1_valid_reg && out_adv, out_valid_reg)
    `AC18_ASSERT_NEXT(a_accept_fills, clk, rst_n, in_accept, s1_valid_reg)

endmodule

`default_nettype wire

@@ verif/affine_cipher_18_letter_check.sv @@
`timescale 1ns / 100ps

module affine_cipher_18_letter_check
    import affc18_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [CHAR_W-1:0]     char_in,
    input  logic                  last_in,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [CHAR_W-1:0]     char_out,
    input  logic                  in_alphabet,
    input  logic                  key_invalid,
    input  logic                  last_out,
    output int                    mismatches,
    output int                    pending
);

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              hit;
        logic              bad_key;
        logic              last;
    } cipher_out_t;

    localparam int RING = 18;
    localparam logic [7:0] LETTER_SET [RING] = '{
        "A", "B", "C", "D", "E", "F", "G", "H", "I",
        "L", "M", "N", "O", "P", "R", "S", "T", "U"
    };

    logic [CFG_DATA_W-1:0] mult_key;
    logic [CFG_DATA_W-1:0] shift_key;
    logic                  decode;
    cipher_out_t           expected_q [$];
    int                    error_count = 0;

    assign mismatches = error_count;

    function automatic int letter_pos(input logic [7:0] c);
        int pos;
        pos = -1;
        for (int k = 0; k < RING; k++)
        begin
            if (LETTER_SET[k] == c)
                pos = k;
        end
        return pos;
    endfunction

    function automatic cipher_out_t cipher_byte(input logic [7:0] c, input logic l);
        cipher_out_t r;
        int          a;
        int          b;
        int          j;
        int          inv;
        logic [7:0]  x;
        a = int'(mult_key) % RING;
        b = int'(shift_key) % RING;
        x = c;
        r.hit = 1'b0;
        r.bad_key = 1'b0;
        r.last = l;
        if (!decode)
        begin
            // fold 'a'..'u' to uppercase, including the three that are not letters here
            if (x >= LOWER_FIRST && x <= LOWER_LAST)
                x = x - CASE_OFFSET;
            r.ch = x;
            j = letter_pos(x);
            if (j >= 0)
            begin
                r.hit = 1'b1;
                r.ch = LETTER_SET[(a * j + b) % RING];
            end
        end
        else
        begin
            inv = 0;
            for (int k = 1; k < RING; k++)
            begin
                if ((k * a) % RING == 1)
                    inv = k;
            end
            r.ch = x;
            j = letter_pos(x);
            r.hit = (j >= 0);
            if (inv == 0)
                r.bad_key = 1'b1;
            else if (j >= 0)
                r.ch = LETTER_SET[((j + RING - b) * inv) % RING];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic check_result();
        cipher_out_t want;
        if (expected_q.size() == 0)
        begin
            report_mismatch("unexpected item", char_out, 0);
        end
        else
        begin
            want = expected_q.pop_front();
            if (char_out !== want.ch)
                report_mismatch("char_out", char_out, want.ch);
            if (in_alphabet !== want.hit)
                report_mismatch("in_alphabet", in_alphabet, want.hit);
            if (key_invalid !== want.bad_key)
                report_mismatch("key_invalid", key_invalid, want.bad_key);
            if (last_out !== want.last)
                report_mismatch("last_out", last_out, want.last);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_key <= 5'd1;
            shift_key <= 5'd0;
            decode <= 1'b0;
            pending <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_KEY_MULT:      mult_key <= cfg_data;
                    REG_KEY_SHIFT:     shift_key <= cfg_data;
                    REG_DECIPHER_MODE: decode <= cfg_data[0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
                check_result();
            if (in_valid && !in_stall)
                expected_q.push_back(cipher_byte(char_in, last_in));
            pending <= expected_q.size();
        end
    end

endmodule

@@ verif/affine_cipher_18_letter_test.sv @@
`timescale 1ns / 100ps

module affine_cipher_18_letter_test;
    import affc18_pkg::*;

    localparam int CYCLE_LIMIT = 100000;
    localparam int NUM_PHASES = 14;
    localparam int TABLE_PHASES = 10;
    localparam int RANDOM_PER_PHASE = 85;
    localparam int SQUEEZE_CYCLES = 64;

    localparam logic [7:0] PROBE_BYTES [12] = '{
        8'h00, 8'hFF, "A", "U", "a", "u", "j", "k", "q", "I", "L", "@"
    };
    // multiplier, shift, mode per phase: extremes, non-invertible keys both ways
    localparam logic [4:0] PHASE_MULT [TABLE_PHASES] = '{
        5'd17, 5'd5, 5'd0, 5'd31, 5'd6, 5'd12, 5'd11, 5'd7, 5'd13, 5'd1
    };
    localparam logic [4:0] PHASE_SHIFT [TABLE_PHASES] = '{
        5'd17, 5'd3, 5'd0, 5'd31, 5'd7, 5'd5, 5'd30, 5'd17, 5'd0, 5'd0
    };
    localparam logic PHASE_MODE [TABLE_PHASES] = '{
        1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1
    };
    localparam string ALPHA_TXT = "ABCDEFGHILMNOPRSTU";

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [CHAR_W-1:0]     char_in;
    logic                  last_in;
    logic                  out_valid;
    logic                  out_stall;
    logic [CHAR_W-1:0]     char_out;
    logic                  in_alphabet;
    logic                  key_invalid;
    logic                  last_out;
    int                    mismatches;
    int                    pending;
    int                    idle_pct = 15;
    bit                    squeeze = 1'b0;
    int                    cycle_count = 0;

    affine_cipher_18_letter uut (.*);

    affine_cipher_18_letter_check checker_i (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // output side: random stalls, plus a long hold-off on request so the block backs up
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (squeeze)
            begin
                out_stall <= 1'b1;
                repeat (SQUEEZE_CYCLES) @(posedge clk);
                squeeze = 1'b0;
            end
            out_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    task automatic send_byte(input logic [7:0] c, input logic l);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        char_in <= c;
        last_in <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_probes();
        for (int k = 0; k < 12; k++)
            send_byte(PROBE_BYTES[k], k == 11);
    endtask

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return ALPHA_TXT[$urandom_range(17)];
        else if (r < 75)
            return 8'h61 + 8'($urandom_range(25));
        else if (r < 85)
            return 8'h41 + 8'($urandom_range(25));
        return 8'($urandom_range(255));
    endfunction

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic set_keys(input logic [4:0] m, input logic [4:0] s, input logic mode);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_KEY_MULT;
        cfg_data <= m;
        @(posedge clk);
        cfg_index <= REG_KEY_SHIFT;
        cfg_data <= s;
        @(posedge clk);
        cfg_index <= REG_DECIPHER_MODE;
        cfg_data <= {4'd0, mode};
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_KEY_MULT;
        cfg_data = '0;
        in_valid = 1'b0;
        char_in = '0;
        last_in = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset keys: plain encipher, identity mapping apart from case folding
        send_probes();
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_drained();
            if (p < TABLE_PHASES)
                set_keys(PHASE_MULT[p], PHASE_SHIFT[p], PHASE_MODE[p]);
            else
                set_keys(5'($urandom_range(31)), 5'($urandom_range(31)), 1'($urandom_range(1)));
            idle_pct = (p == 4) ? 0 : 15;
            if (p == 2 || p == 9)
                squeeze = 1'b1;
            if (p == 1)
                send_probes();
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                send_byte(pick_byte(), $urandom_range(7) == 0);
        end
        wait_drained();
        repeat (8) @(posedge clk);

        if (mismatches == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
